/* design/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sorted priority queue package
// Shared types, codes and default sizes for the sorted priority queue core.
// ============================================================================
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;
    localparam int KEY_W         = 40;
    localparam int PRIO_W        = 8;
    localparam int COUNT_W       = 5;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_COUNT   = 2'd3
    } spq_op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } spq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_FIND_RD,
        S_FIND_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } spq_state_t;

    typedef struct packed {
        spq_op_t             command;
        logic [KEY_W-1:0]    item_key;
        logic [PRIO_W-1:0]   item_priority;
    } spq_cmd_t;

    typedef struct packed {
        spq_status_t         status;
        logic [KEY_W-1:0]    out_key;
        logic [PRIO_W-1:0]   out_priority;
        logic [COUNT_W-1:0]  ahead_count;
        logic [COUNT_W-1:0]  occupancy;
        logic                is_empty;
    } spq_res_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } spq_mem_ctl_t;

endpackage
`default_nettype wire

/* design/spq_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sorted priority queue entry store
// Single-port-write, single-port-read memory of entries with registered read.
// ============================================================================
module spq_store #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int WIDTH = spq_pkg::KEY_W + spq_pkg::PRIO_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire spq_pkg::spq_mem_ctl_t      mem_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);
    import spq_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* design/spq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sorted priority queue sequencer
// Walks the entry store one entry at a time to insert, find and close gaps.
// ============================================================================
module spq_ctrl #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cmd_valid,
    input  wire spq_pkg::spq_cmd_t                        cmd,
    output logic                                          cmd_stall,
    input  wire logic                                     res_free,
    output logic                                          res_load,
    output spq_pkg::spq_res_t                             res,
    output spq_pkg::spq_mem_ctl_t                         mem_ctl,
    output logic [$clog2(DEPTH)-1:0]                      wr_addr,
    output logic [spq_pkg::KEY_W+PRIORITY_BITS-1:0]       wr_data,
    output logic [$clog2(DEPTH)-1:0]                      rd_addr,
    input  wire logic [spq_pkg::KEY_W+PRIORITY_BITS-1:0]  rd_data
);
    import spq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    spq_state_t               state_reg, state_next;
    spq_op_t                  op_reg, op_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    spq_status_t              status_reg, status_next;
    logic [KEY_W-1:0]         okey_reg, okey_next;
    logic [PRIORITY_BITS-1:0] oprio_reg, oprio_next;
    logic [CW-1:0]            ahead_reg, ahead_next;

    logic [KEY_W-1:0]         rd_key;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic                     key_hit;
    logic                     prio_gt;
    logic [CW-1:0]            idx_inc;
    logic [CW-1:0]            idx_dec;
    logic                     at_count;
    logic                     is_full;
    logic                     idx_zero;
    logic                     last;

    assign rd_key   = rd_data[KEY_W+PRIORITY_BITS-1:PRIORITY_BITS];
    assign rd_prio  = rd_data[PRIORITY_BITS-1:0];

    // The shared compare unit: one stored entry against the request each step.
    // A dequeue is a delete that matches at the head.
    assign key_hit  = (rd_key == key_reg) || (op_reg == OP_DEQUEUE);
    assign prio_gt  = rd_prio > prio_reg;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign at_count = idx_reg == count_reg;
    assign is_full  = count_reg == CW'(DEPTH);
    assign idx_zero = idx_reg == '0;
    assign last     = idx_inc >= count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        prio_reg   <= prio_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        okey_reg   <= okey_next;
        oprio_reg  <= oprio_next;
        ahead_reg  <= ahead_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.command)
                        OP_INSERT:  state_next = is_full ? S_DONE : S_INS_RD;
                        OP_DEQUEUE: state_next = (count_reg == '0) ? S_DONE : S_FIND_RD;
                        default:    state_next = S_FIND_RD;
                    endcase
                end
            end
            S_INS_RD:   state_next = idx_zero ? S_DONE : S_INS_CMP;
            S_INS_CMP:  state_next = prio_gt ? S_INS_RD : S_DONE;
            S_FIND_RD:  state_next = at_count ? S_DONE : S_FIND_CMP;
            S_FIND_CMP:
            begin
                if (!key_hit)
                begin
                    state_next = S_FIND_RD;
                end
                else if (op_reg == OP_COUNT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:    state_next = last ? S_DONE : S_SH_WR;
            S_SH_WR:    state_next = S_SH_RD;
            S_DONE:     state_next = res_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        op_next     = op_reg;
        key_next    = key_reg;
        prio_next   = prio_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        okey_next   = okey_reg;
        oprio_next  = oprio_reg;
        ahead_next  = ahead_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = cmd.command;
                    key_next    = cmd.item_key;
                    prio_next   = PRIORITY_BITS'(cmd.item_priority);
                    okey_next   = '0;
                    oprio_next  = '0;
                    ahead_next  = '0;
                    status_next = STAT_OK;
                    idx_next    = (cmd.command == OP_INSERT) ? count_reg : '0;
                    if ((cmd.command == OP_INSERT) && is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    if ((cmd.command == OP_DEQUEUE) && (count_reg == '0))
                    begin
                        status_next = STAT_EMPTY;
                    end
                end
            end
            S_INS_RD:
            begin
                if (idx_zero)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            S_INS_CMP:
            begin
                if (prio_gt)
                begin
                    idx_next = idx_dec;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            S_FIND_RD:
            begin
                if (at_count)
                begin
                    status_next = STAT_NOT_FOUND;
                    if (op_reg == OP_COUNT)
                    begin
                        ahead_next = count_reg;
                    end
                end
            end
            S_FIND_CMP:
            begin
                if (key_hit)
                begin
                    okey_next  = rd_key;
                    oprio_next = rd_prio;
                    if (op_reg == OP_COUNT)
                    begin
                        ahead_next = idx_reg;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_SH_RD:
            begin
                if (last)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_SH_WR:
            begin
                idx_next = idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    // Outputs: store port controls, handshake and result.
    always_comb
    begin
        mem_ctl   = '0;
        rd_addr   = idx_reg[IW-1:0];
        wr_addr   = idx_reg[IW-1:0];
        wr_data   = {key_reg, prio_reg};
        cmd_stall = state_reg != S_IDLE;
        res_load  = (state_reg == S_DONE) && res_free;
        case (state_reg)
            S_INS_RD:
            begin
                // Walk from the tail toward the head, moving larger entries back.
                if (idx_zero)
                begin
                    mem_ctl.wr_en = 1'b1;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = idx_dec[IW-1:0];
                end
            end
            S_INS_CMP:
            begin
                mem_ctl.wr_en = 1'b1;
                if (prio_gt)
                begin
                    wr_data = rd_data;
                end
            end
            S_FIND_RD:
            begin
                mem_ctl.rd_en = !at_count;
            end
            S_SH_RD:
            begin
                mem_ctl.rd_en = !last;
                rd_addr       = idx_inc[IW-1:0];
            end
            S_SH_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_data       = rd_data;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.status       = status_reg;
        res.out_key      = okey_reg;
        res.out_priority = PRIO_W'(oprio_reg);
        res.ahead_count  = COUNT_W'(ahead_reg);
        res.occupancy    = COUNT_W'(count_reg);
        res.is_empty     = count_reg == '0;
    end

endmodule
`default_nettype wire

/* design/sorted_priority_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sorted priority queue core
// Bounded queue of key and priority entries kept in serving order.
// ============================================================================
// Usage:
//   A request on cmd_data (cmd_valid / cmd_stall) inserts an entry, dequeues
//   the head, deletes the first entry with a given key, or counts the entries
//   ahead of that key. Every request gives exactly one response on res_data
//   (res_valid / res_stall) with status, touched entry and occupancy.
//   A request visits stored entries one at a time through the single read
//   port of the entry store: full and empty requests visit none, and a
//   delete or failed search on a full queue visits every entry. cmd_stall
//   stays high from acceptance until the response is placed in the output
//   register; requests are handled one at a time.
//   The output register lets a new request be accepted while an earlier
//   response waits. If res_stall holds the register full, the sequencer
//   waits at the end of its request and res_data does not change.
//   Reset empties the queue at once; entry contents are not cleared and are
//   never read before they are written.
// ============================================================================
module sorted_priority_queue_core #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire spq_pkg::spq_cmd_t  cmd_data,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output spq_pkg::spq_res_t       res_data
);
    import spq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int DW = KEY_W + PRIORITY_BITS;

    spq_mem_ctl_t mem_ctl;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_data;
    logic          res_free;
    logic          res_load;
    spq_res_t      res;

    logic          res_valid_reg, res_valid_next;
    spq_res_t      res_data_reg;

    spq_ctrl #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_data),
        .cmd_stall (cmd_stall),
        .res_free  (res_free),
        .res_load  (res_load),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    spq_store #(
        .DEPTH (DEPTH),
        .WIDTH (DW)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
`default_nettype wire

/* design/spq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sorted priority queue port checker
// Checks request and response behavior seen at the core's ports.
// ============================================================================
module spq_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire logic               cmd_stall,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  wire spq_pkg::spq_res_t  res_data
);
    import spq_pkg::*;

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request accepted while previous one still in progress");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.is_empty == (res_data.occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.status == STAT_EMPTY)) |->
        (res_data.is_empty && (res_data.out_key == '0) && (res_data.ahead_count == '0)))
        else $error("empty status with nonempty queue or stray entry data");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.status == STAT_FULL)) |->
        (!res_data.is_empty && (res_data.out_key == '0) && (res_data.out_priority == '0)))
        else $error("full status with empty queue or stray entry data");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
        else $error("stalled response changed");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
`default_nettype wire

/* tb/sv/sorted_priority_queue_core_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority queue core testbench
// Sends insert, dequeue, delete and count requests through the command port,
// keeps a mirror of the queue contents, and compares every response field by
// field against what the mirror predicts, under random idling on both sides.
// ============================================================================
module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 630;
    localparam int CALM_ITEMS     = 100;
    localparam int PHASE_ITEMS    = 60;
    localparam int DRAIN_CYCLES   = 80;
    localparam int POOL_SIZE      = 24;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    // Mirror of the queue contents plus the responses still owed by the block.
    class queue_mirror;
        localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'((1 << PRIO_BITS_DEF) - 1);

        logic [KEY_W-1:0]  keys  [DEPTH_DEF];
        logic [PRIO_W-1:0] prios [DEPTH_DEF];
        int                held;
        spq_res_t          pending [$];
        int                errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void close_gap(int pos);
            for (int i = pos; i + 1 < held; i++)
            begin
                keys[i]  = keys[i + 1];
                prios[i] = prios[i + 1];
            end
            held--;
        endfunction

        function void note_request(spq_cmd_t req);
            spq_res_t          want;
            logic [PRIO_W-1:0] prio;
            int                pos;

            want        = '0;
            want.status = STAT_OK;
            prio        = req.item_priority & PRIO_MASK;
            case (req.command)
                OP_INSERT:
                begin
                    if (held >= DEPTH_DEF)
                        want.status = STAT_FULL;
                    else
                    begin
                        // A new entry lines up behind every entry of equal priority.
                        pos = 0;
                        while (pos < held && prios[pos] <= prio)
                            pos++;
                        for (int i = held; i > pos; i--)
                        begin
                            keys[i]  = keys[i - 1];
                            prios[i] = prios[i - 1];
                        end
                        keys[pos]  = req.item_key;
                        prios[pos] = prio;
                        held++;
                    end
                end
                OP_DEQUEUE:
                begin
                    if (held == 0)
                        want.status = STAT_EMPTY;
                    else
                    begin
                        want.out_key      = keys[0];
                        want.out_priority = prios[0];
                        close_gap(0);
                    end
                end
                default:
                begin
                    pos = 0;
                    while (pos < held && keys[pos] != req.item_key)
                        pos++;
                    if (pos >= held)
                    begin
                        want.status = STAT_NOT_FOUND;
                        if (req.command == OP_COUNT)
                            want.ahead_count = COUNT_W'(held);
                    end
                    else
                    begin
                        want.out_key      = keys[pos];
                        want.out_priority = prios[pos];
                        if (req.command == OP_DELETE)
                            close_gap(pos);
                        else
                            want.ahead_count = COUNT_W'(pos);
                    end
                end
            endcase
            want.occupancy = COUNT_W'(held);
            want.is_empty  = (held == 0);
            pending.push_back(want);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s expected %0h actual %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_response(spq_res_t got);
            spq_res_t want;

            if (pending.size() == 0)
            begin
                $error("response with no request outstanding, status %0d key %0h",
                       got.status, got.out_key);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_key", want.out_key, got.out_key);
            compare_field("out_priority", want.out_priority, got.out_priority);
            compare_field("ahead_count", want.ahead_count, got.ahead_count);
            compare_field("occupancy", want.occupancy, got.occupancy);
            compare_field("is_empty", want.is_empty, got.is_empty);
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    spq_cmd_t  cmd_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    spq_res_t  res_data;

    int               idle_pct   = 0;
    int               stall_left = 0;
    logic [KEY_W-1:0] key_pool [$];
    queue_mirror      mirror     = new();

    sorted_priority_queue_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver side: random stall bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(0, 9);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                mirror.check_response(res_data);
            if (cmd_valid && !cmd_stall)
                mirror.note_request(cmd_data);
        end
    end

    initial
    begin
        int quiet;

        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Presents one request, after an optional idle gap, and returns at the
    // edge where it is accepted. Valid stays high into the next request.
    task automatic send_request(input spq_op_t op, input logic [KEY_W-1:0] key,
                                input logic [PRIO_W-1:0] prio);
        spq_cmd_t req;
        int       gap;

        req.command       = op;
        req.item_key      = key;
        req.item_priority = prio;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= req;
        do
            @(posedge clk);
        while (cmd_stall);
        if (op == OP_INSERT)
        begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_SIZE)
                void'(key_pool.pop_front());
        end
    endtask

    initial
    begin
        int                n;
        int                roll;
        bit                filling;
        spq_op_t           op;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;

        repeat (8) @(posedge clk);
        rst_n    <= 1'b1;
        idle_pct <= 20;
        @(posedge clk);

        // Empty queue cases first.
        send_request(OP_DEQUEUE, KEY_MAX, 8'hFF);
        send_request(OP_DELETE, KEY_MAX, 8'h00);
        send_request(OP_COUNT, '0, 8'h00);

        // Extremes of key and priority, equal priorities and a duplicate key.
        send_request(OP_INSERT, KEY_MAX, 8'hFF);
        send_request(OP_INSERT, '0, 8'h00);
        send_request(OP_INSERT, 40'hAA_AAAA_AAAA, 8'h80);
        send_request(OP_INSERT, 40'h55_5555_5555, 8'h80);
        send_request(OP_INSERT, 40'h55_5555_5555, 8'h7F);
        send_request(OP_COUNT, 40'h55_5555_5555, 8'h00);
        send_request(OP_COUNT, 40'h12_3456_789A, 8'h00);
        send_request(OP_DELETE, 40'h55_5555_5555, 8'h00);
        send_request(OP_DELETE, 40'h12_3456_789A, 8'h00);
        send_request(OP_DEQUEUE, '0, 8'h00);

        // Fill to capacity, then one insert too many.
        for (n = 0; n < DEPTH_DEF - 3; n++)
            send_request(OP_INSERT, KEY_W'(100 + n), PRIO_W'($urandom_range(0, 255)));
        send_request(OP_INSERT, 40'hFF_0000_0001, 8'h01);
        send_request(OP_COUNT, KEY_MAX, 8'h00);

        // Alternate filling and draining phases so both full and empty recur.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                filling = ((n / PHASE_ITEMS) % 2 == 0);
                // The final stretch of the run keeps both sides busy.
                if (n < RANDOM_ITEMS - CALM_ITEMS)
                begin
                    case ($urandom_range(0, 2))
                        0: idle_pct <= 0;
                        1: idle_pct <= 15;
                        default: idle_pct <= 40;
                    endcase
                end
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                idle_pct <= 0;

            roll = $urandom_range(0, 99);
            if (filling)
                op = (roll < 60) ? OP_INSERT : (roll < 75) ? OP_DEQUEUE :
                     (roll < 90) ? OP_DELETE : OP_COUNT;
            else
                op = (roll < 20) ? OP_INSERT : (roll < 55) ? OP_DEQUEUE :
                     (roll < 80) ? OP_DELETE : OP_COUNT;

            roll = $urandom_range(0, 99);
            if (op != OP_INSERT && key_pool.size() > 0 && roll < 60)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (roll < 80)
                key = KEY_W'($urandom_range(0, 7));
            else
                key = {8'($urandom()), 32'($urandom())};

            if ($urandom_range(0, 3) == 0)
                prio = PRIO_W'($urandom_range(0, 3));
            else
                prio = PRIO_W'($urandom_range(0, 255));

            send_request(op, key, prio);
        end
        cmd_valid <= 1'b0;

        while (mirror.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
design/spq_pkg.sv
design/spq_store.sv
design/spq_ctrl.sv
design/sorted_priority_queue_core.sv
design/spq_checker.sv
tb/sv/sorted_priority_queue_core_tb.sv
